// ===== design/ffslp_pkg.sv =====
// Package for the fixed-format sensor line parser.
// Holds line layout constants, payload types and the byte position decoder.
// No dependencies.
package ffslp_pkg;

	localparam int unsigned NumFields = 17;
	localparam int unsigned NumSigned = 16;
	localparam int unsigned AccWidth  = 24;

	localparam logic [7:0] LineLen    = 8'd129;
	localparam logic [7:0] BumpPos    = 8'd4;
	localparam logic [7:0] PosMax     = 8'd255;
	localparam logic [7:0] AsciiZero  = 8'd48;
	localparam logic [7:0] AsciiMinus = 8'd45;

	localparam logic [7:0] SignPos [NumSigned] = '{
		8'd9, 8'd16, 8'd23, 8'd32, 8'd39, 8'd46, 8'd53, 8'd62,
		8'd69, 8'd76, 8'd85, 8'd92, 8'd99, 8'd108, 8'd115, 8'd122
	};

	typedef logic [7:0]         line_byte_t;
	typedef logic [4:0]         field_index_t;
	typedef logic signed [22:0] field_value_t;
	typedef logic signed [AccWidth-1:0] acc_t;

	typedef enum logic [2:0] {
		PK_NONE,
		PK_BUMP_HI,
		PK_BUMP_LO,
		PK_SIGN,
		PK_DIGIT,
		PK_DIGIT_LAST
	} pos_kind_t;

	typedef struct packed {
		pos_kind_t    kind;
		field_index_t slot;
	} pos_decode_t;

	// What the byte at position p means in the fixed layout
	function automatic pos_decode_t decode_pos(input logic [7:0] p);
		pos_decode_t r;
		logic [8:0]  s;
		logic [8:0]  pe;
		r.kind = PK_NONE;
		r.slot = '0;
		pe = {1'b0, p};
		if (p == BumpPos) begin
			r.kind = PK_BUMP_HI;
		end else if (p == BumpPos + 8'd1) begin
			r.kind = PK_BUMP_LO;
		end else begin
			for (int i = 0; i < NumSigned; i++) begin
				s = {1'b0, SignPos[i]};
				if (pe == s) begin
					r.kind = PK_SIGN;
					r.slot = field_index_t'(i + 1);
				end else if (pe > s && pe <= s + 9'd5) begin
					r.kind = (pe == s + 9'd5) ? PK_DIGIT_LAST : PK_DIGIT;
					r.slot = field_index_t'(i + 1);
				end
			end
		end
		return r;
	endfunction

endpackage

// ===== design/ffslp_if.sv =====
// Handshake channels of the sensor line parser: byte input and result output.
// Depends on ffslp_pkg for payload types.
interface ffslp_in_if import ffslp_pkg::*; ();
	logic       valid;
	logic       ready;
	line_byte_t line_byte;
	logic       end_of_line;

	modport source(output valid, line_byte, end_of_line, input ready);
	modport sink(input valid, line_byte, end_of_line, output ready);
endinterface

interface ffslp_out_if import ffslp_pkg::*; ();
	logic         valid;
	logic         ready;
	field_index_t field_index;
	field_value_t field_value;
	logic         status;
	logic         last_result;

	modport source(output valid, field_index, field_value, status, last_result, input ready);
	modport sink(input valid, field_index, field_value, status, last_result, output ready);
endinterface

// ===== design/fixed_format_sensor_line_parser.sv =====
// Top level of the fixed-format sensor line parser.
// Depends on ffslp_pkg and the channel interfaces in ffslp_if.sv.
//
// Usage:
// - line: one text byte per word, end_of_line set on the final byte.
//   Bytes are decoded on acceptance: a position compare and a x10
//   accumulate update the running field and the field registers.
// - result: on the final byte of a 129-byte line, 17 words follow with
//   field_index 0 to 16, status 0, last_result on index 16. Any other
//   length gives a single word with status 1 and value 0.
// - Throughput: one byte per cycle. The first result is valid the cycle
//   after the final byte; the words then leave one per cycle.
// - The results are held in a snapshot register bank, so bytes of the
//   next line keep flowing while they drain. Only a final byte that
//   arrives while results are still pending is held off; it enters in
//   the cycle the last pending word leaves.
// - A stalled receiver holds the current word; nothing is dropped.
// - Reset clears the position, accumulator, sign flag and emitter;
//   the field registers are not reset.
module fixed_format_sensor_line_parser
	import ffslp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	ffslp_in_if.sink    line,
	ffslp_out_if.source result
);

	logic [7:0]   pos_q;
	acc_t         acc_q;
	logic         neg_q;
	acc_t         store_q [NumFields];

	acc_t         shadow_q [NumFields];
	field_index_t idx_q;
	logic         busy_q;
	logic         err_q;

	pos_decode_t  dec;
	acc_t         digit;
	acc_t         acc_new;
	logic         in_fire;
	logic         out_fire;
	logic         out_last;

	assign line.ready = !busy_q || !line.end_of_line || (out_fire && out_last);
	assign in_fire    = line.valid && line.ready;

	assign dec     = decode_pos(pos_q);
	assign digit   = $signed({16'd0, line.line_byte}) - $signed({16'd0, AsciiZero});
	assign acc_new = (acc_q <<< 3) + (acc_q <<< 1) + digit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			acc_q <= '0;
			neg_q <= 1'b0;
		end else if (in_fire) begin
			if (line.end_of_line) begin
				pos_q <= '0;
				acc_q <= '0;
				neg_q <= 1'b0;
			end else begin
				pos_q <= (pos_q == PosMax) ? PosMax : pos_q + 8'd1;
				unique case (dec.kind)
					PK_BUMP_HI: acc_q <= digit;
					PK_SIGN: begin
						acc_q <= '0;
						neg_q <= (line.line_byte == AsciiMinus);
					end
					PK_DIGIT, PK_DIGIT_LAST: acc_q <= acc_new;
					PK_NONE, PK_BUMP_LO: ;
					default: ;
				endcase
			end
		end
	end

	// field registers, each written at most once per line
	always_ff @(posedge clk) begin
		if (in_fire && dec.kind == PK_BUMP_LO) begin
			store_q[0] <= acc_new;
		end
		if (in_fire && dec.kind == PK_DIGIT_LAST) begin
			store_q[dec.slot] <= neg_q ? -acc_new : acc_new;
		end
	end

	assign out_fire = result.valid && result.ready;
	assign out_last = err_q || (idx_q == field_index_t'(NumFields - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			err_q  <= 1'b0;
			idx_q  <= '0;
		end else if (in_fire && line.end_of_line) begin
			busy_q <= 1'b1;
			err_q  <= (pos_q != LineLen - 8'd1);
			idx_q  <= '0;
		end else if (out_fire) begin
			if (out_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && line.end_of_line) begin
			shadow_q <= store_q;
		end
	end

	assign result.valid       = busy_q;
	assign result.field_index = err_q ? '0 : idx_q;
	assign result.field_value = err_q ? '0 : field_value_t'(shadow_q[idx_q][22:0]);
	assign result.status      = err_q;
	assign result.last_result = out_last;

endmodule

// ===== dv/fixed_format_sensor_line_parser_tb.sv =====
// Self-checking bench for fixed_format_sensor_line_parser: sends text lines word by word,
// predicts the decoded field words and checks every result word in order.
// Depends on ffslp_pkg, the channel interfaces in ffslp_if.sv and the parser top level.
module fixed_format_sensor_line_parser_tb
	import ffslp_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 600000;
	localparam int LinesPerPhase = 14;
	localparam line_byte_t SignPlus = 8'd43;
	localparam line_byte_t Filler = 8'd44;

	typedef enum logic [2:0] {
		FILL_ASCII,
		FILL_ANY,
		FILL_ZERO_DIGITS,
		FILL_TOP_POS,
		FILL_TOP_NEG,
		FILL_LOW_NEG,
		FILL_NINES_MIXED
	} fill_t;

	typedef enum logic [1:0] {
		ROLE_OTHER,
		ROLE_SIGN,
		ROLE_DIGIT
	} role_t;

	typedef struct packed {
		field_index_t field_index;
		field_value_t field_value;
		logic         status;
		logic         last_result;
	} result_t;

	typedef struct packed {
		logic [8:0] len;
		fill_t      fill;
		logic       typed;
		result_t    want;
	} line_row_t;

	localparam result_t LineError = '{5'd0, 23'sd0, 1'b1, 1'b1};

	localparam line_row_t DirectedLines [13] = '{
		'{9'd1,   FILL_ANY,         1'b1, LineError},
		'{9'd5,   FILL_ASCII,       1'b1, LineError},
		'{9'd128, FILL_ZERO_DIGITS, 1'b1, LineError},
		'{9'd130, FILL_NINES_MIXED, 1'b1, LineError},
		'{9'd255, FILL_ANY,         1'b1, LineError},
		'{9'd300, FILL_ANY,         1'b1, LineError},
		'{9'd129, FILL_ZERO_DIGITS, 1'b0, LineError},
		'{9'd129, FILL_TOP_POS,     1'b0, LineError},
		'{9'd129, FILL_TOP_NEG,     1'b0, LineError},
		'{9'd129, FILL_LOW_NEG,     1'b0, LineError},
		'{9'd129, FILL_NINES_MIXED, 1'b0, LineError},
		'{9'd129, FILL_ANY,         1'b0, LineError},
		'{9'd129, FILL_ASCII,       1'b0, LineError}
	};

	logic clk;
	logic arst_n;

	ffslp_in_if  line_ch ();
	ffslp_out_if res_ch ();

	fixed_format_sensor_line_parser uut (
		.clk    (clk),
		.arst_n (arst_n),
		.line   (line_ch),
		.result (res_ch)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	int      send_gap_pct;
	int      recv_gap_pct;
	bit      failed;
	int      cycle_count;
	result_t expected_fields [$];

	// line decoder state
	int      pred_pos;
	int      pred_acc;
	bit      pred_neg;
	int      pred_store [NumFields];
	result_t pred_buf [NumFields];

	function automatic void layout_of(input int p, output role_t role, output int slot);
		role = ROLE_OTHER;
		slot = 0;
		if (p == int'(BumpPos) || p == int'(BumpPos) + 1) begin
			role = ROLE_DIGIT;
		end else begin
			for (int i = 0; i < NumSigned; i++) begin
				if (p == int'(SignPos[i])) begin
					role = ROLE_SIGN;
					slot = i + 1;
				end else if (p > int'(SignPos[i]) && p <= int'(SignPos[i]) + 5) begin
					role = ROLE_DIGIT;
					slot = i + 1;
				end
			end
		end
	endfunction

	// Fills pred_buf with the words caused by one accepted byte, returns their number
	function automatic int decode_line_byte(input line_byte_t b, input logic eol);
		role_t role;
		int    slot;
		int    d;
		int    count;
		layout_of(pred_pos, role, slot);
		d = int'(b) - int'(AsciiZero);
		if (pred_pos == int'(BumpPos)) begin
			pred_acc = d;
		end else if (pred_pos == int'(BumpPos) + 1) begin
			pred_store[0] = pred_acc * 10 + d;
		end else if (role == ROLE_SIGN) begin
			pred_neg = (b == AsciiMinus);
			pred_acc = 0;
		end else if (role == ROLE_DIGIT) begin
			pred_acc = pred_acc * 10 + d;
			if (pred_pos == int'(SignPos[slot-1]) + 5)
				pred_store[slot] = pred_neg ? -pred_acc : pred_acc;
		end
		count = (pred_pos < int'(PosMax)) ? pred_pos + 1 : int'(PosMax);
		pred_pos = count;
		if (!eol)
			return 0;
		pred_pos = 0;
		pred_acc = 0;
		pred_neg = 1'b0;
		if (count != int'(LineLen)) begin
			pred_buf[0] = '{5'd0, 23'sd0, 1'b1, 1'b1};
			return 1;
		end
		for (int k = 0; k < NumFields; k++)
			pred_buf[k] = '{field_index_t'(k), field_value_t'(pred_store[k]), 1'b0,
				k == NumFields - 1};
		return NumFields;
	endfunction

	function automatic line_byte_t make_byte(input fill_t fill, input role_t role);
		int r;
		r = $urandom_range(99);
		case (fill)
			FILL_ZERO_DIGITS: begin
				return (role == ROLE_SIGN) ? SignPlus : (role == ROLE_DIGIT) ? AsciiZero : Filler;
			end
			FILL_TOP_POS: begin
				return (role == ROLE_SIGN) ? SignPlus : 8'hFF;
			end
			FILL_TOP_NEG: begin
				return (role == ROLE_SIGN) ? AsciiMinus : (role == ROLE_DIGIT) ? 8'hFF : Filler;
			end
			FILL_LOW_NEG: begin
				return (role == ROLE_SIGN) ? AsciiMinus : 8'h00;
			end
			FILL_NINES_MIXED: begin
				if (role == ROLE_SIGN)
					return r[0] ? AsciiMinus : SignPlus;
				return (role == ROLE_DIGIT) ? AsciiZero + 8'd9 : Filler;
			end
			FILL_ANY: begin
				return line_byte_t'($urandom_range(255));
			end
			default: begin
				if (role == ROLE_SIGN)
					return (r < 45) ? AsciiMinus : (r < 90) ? SignPlus :
						line_byte_t'($urandom_range(255));
				if (role == ROLE_DIGIT)
					return (r < 90) ? AsciiZero + line_byte_t'($urandom_range(9)) :
						line_byte_t'($urandom_range(255));
				return line_byte_t'($urandom_range(32, 126));
			end
		endcase
	endfunction

	// Entered and left at a falling edge
	task automatic send_byte(input line_byte_t b, input logic eol, input bit typed,
		input result_t want);
		int n;
		while ($urandom_range(99) < send_gap_pct) begin
			line_ch.valid <= 1'b0;
			@(negedge clk);
		end
		line_ch.valid <= 1'b1;
		line_ch.line_byte <= b;
		line_ch.end_of_line <= eol;
		do
			@(posedge clk);
		while (!line_ch.ready);
		n = decode_line_byte(b, eol);
		if (eol && typed) begin
			expected_fields.push_back(want);
		end else begin
			for (int k = 0; k < n; k++)
				expected_fields.push_back(pred_buf[k]);
		end
		@(negedge clk);
	endtask

	task automatic send_line(input int len, input fill_t fill, input bit typed,
		input result_t want);
		role_t role;
		int    slot;
		for (int p = 0; p < len; p++) begin
			layout_of(p, role, slot);
			send_byte(make_byte(fill, role), p == len - 1, typed, want);
		end
	endtask

	task automatic send_random_lines(input int n_lines);
		int r;
		for (int i = 0; i < n_lines; i++) begin
			r = $urandom_range(99);
			if (r < 65)
				send_line(int'(LineLen), FILL_ASCII, 1'b0, LineError);
			else if (r < 78)
				send_line(int'(LineLen), FILL_ANY, 1'b0, LineError);
			else if (r < 90)
				send_line($urandom_range(1, int'(LineLen) - 1), r[0] ? FILL_ASCII : FILL_ANY,
					1'b0, LineError);
			else if (r < 96)
				send_line($urandom_range(int'(LineLen) + 1, 300), FILL_ANY, 1'b0, LineError);
			else
				send_line(r[0] ? int'(LineLen) - 1 : int'(LineLen) + 1, FILL_ASCII, 1'b0,
					LineError);
		end
	endtask

	task automatic drain_results();
		line_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (expected_fields.size() != 0);
	endtask

	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
	end

	always @(posedge clk) begin : check_words
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_fields.size() == 0) begin
				$error("result word with nothing expected: field_index %0d field_value %0d",
					res_ch.field_index, res_ch.field_value);
				failed = 1'b1;
			end else begin
				want = expected_fields.pop_front();
				if (res_ch.field_index !== want.field_index) begin
					$error("field_index: expected %0d, actual %0d", want.field_index,
						res_ch.field_index);
					failed = 1'b1;
				end
				if (res_ch.field_value !== want.field_value) begin
					$error("field_value: expected %0d, actual %0d", $signed(want.field_value),
						res_ch.field_value);
					failed = 1'b1;
				end
				if (res_ch.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, res_ch.status);
					failed = 1'b1;
				end
				if (res_ch.last_result !== want.last_result) begin
					$error("last_result: expected %0d, actual %0d", want.last_result,
						res_ch.last_result);
					failed = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		failed = 1'b0;
		cycle_count = 0;
		line_ch.valid = 1'b0;
		line_ch.line_byte = '0;
		line_ch.end_of_line = 1'b0;
		res_ch.ready = 1'b0;
		pred_pos = 0;
		pred_acc = 0;
		pred_neg = 1'b0;
		foreach (pred_store[i])
			pred_store[i] = 0;
		send_gap_pct = 35;
		recv_gap_pct = 73;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < $size(DirectedLines); i++)
			send_line(int'(DirectedLines[i].len), DirectedLines[i].fill,
				DirectedLines[i].typed, DirectedLines[i].want);
		send_random_lines(LinesPerPhase);
		// hold the sender off until every field word is out
		drain_results();

		send_gap_pct = 73;
		recv_gap_pct = 35;
		send_random_lines(LinesPerPhase);
		drain_results();

		send_gap_pct = 0;
		recv_gap_pct = 0;
		send_random_lines(LinesPerPhase);
		drain_results();

		repeat (16) @(negedge clk);
		if (failed)
			$display("SCOREBOARD MISMATCH");
		else
			$display("SCOREBOARD CLEAN");
		$finish;
	end

endmodule

// ===== files.f =====
design/ffslp_pkg.sv
design/ffslp_if.sv
design/fixed_format_sensor_line_parser.sv
dv/fixed_format_sensor_line_parser_tb.sv
